/* rtl/track_route_switch_setter_macros.svh */
// Assertion shorthands for the route switch setter.
// Each expands to one labeled concurrent assertion clocked on clk, off during reset.
`ifndef TRACK_ROUTE_SWITCH_SETTER_MACROS_SVH
`define TRACK_ROUTE_SWITCH_SETTER_MACROS_SVH

// Same-cycle implication.
`define TRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/trss_pkg.sv */
`default_nettype none

package trss_pkg;

  localparam int NODE_COUNT = 256;
  localparam int DIST_BITS  = 16;
  localparam int MAX_HOPS   = 63;

  localparam int NODE_W     = 8;
  localparam int DIST_IN_W  = 16;
  localparam int NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int HOP_W      = $clog2(MAX_HOPS + 1);
  localparam int DIST_DEPTH = 1 << (2 * NODE_IDX_W);

  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [HOP_W-1:0]     hop_t;

  typedef enum logic [1:0] {
    ACT_LOAD_NODE = 2'd0,
    ACT_LOAD_DIST = 2'd1,
    ACT_ROUTE     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_SWITCH = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  branch;
    node_t straight;
    node_t curved;
  } node_rec_t;

  typedef struct packed {
    logic  start;
    logic  load_node;
    logic  load_dist;
    logic  rd_node;
    logic  rd_ds;
    logic  rd_dc;
    logic  adv_ahead;
    logic  adv_branch;
    logic  emit;
    kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_dst;
    logic stop;
    logic is_branch;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic node_in_range(node_t n);
    return {1'b0, n} < (NODE_W + 1)'(NODE_COUNT);
  endfunction

endpackage

`default_nettype wire

/* rtl/trss_if.sv */
`default_nettype none

interface trss_in_if;
  import trss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  node_t                node_id;
  node_t                target_id;
  logic                 is_branch;
  node_t                next_straight;
  node_t                next_curved;
  logic [DIST_IN_W-1:0] distance;

  modport source (
    output valid, action, node_id, target_id, is_branch, next_straight, next_curved,
           distance,
    input  ready
  );

  modport sink (
    input  valid, action, node_id, target_id, is_branch, next_straight, next_curved,
           distance,
    output ready
  );
endinterface

interface trss_out_if;
  import trss_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  node_t      switch_node;
  logic       set_curved;
  logic       last;

  modport source (
    output valid, kind, switch_node, set_curved, last,
    input  ready
  );

  modport sink (
    input  valid, kind, switch_node, set_curved, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/track_route_switch_setter.sv */
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    action, node_id, target_id, is_branch, next_straight,
//                               next_curved, distance
// out_ch    out  valid/ready    kind, switch_node, set_curved, last
//
// Node and distance loads are written as their in_ch words are accepted.
// A route walk does one node read per plain hop and, per branch hop, a node read then two
// distance reads through the single distance table port and a switch word; it ends with
// the final word after at most MAX_HOPS hops, and waits while out_ch stalls.
// in_ch is ready only between walks; the final word may still sit in the output register.
// Reset is synchronous on rst_n; the node and distance tables are not cleared.
`default_nettype none

module track_route_switch_setter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trss_in_if.sink    in_ch,
  trss_out_if.source out_ch
);
  import trss_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  trss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trss_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_node_id       (in_ch.node_id),
    .in_target_id     (in_ch.target_id),
    .in_is_branch     (in_ch.is_branch),
    .in_next_straight (in_ch.next_straight),
    .in_next_curved   (in_ch.next_curved),
    .in_distance      (in_ch.distance),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_switch_node  (out_ch.switch_node),
    .out_set_curved   (out_ch.set_curved),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

/* rtl/trss_datapath.sv */
`default_nettype none

module trss_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire trss_pkg::node_t               in_node_id,
  input  wire trss_pkg::node_t               in_target_id,
  input  wire logic                          in_is_branch,
  input  wire trss_pkg::node_t               in_next_straight,
  input  wire trss_pkg::node_t               in_next_curved,
  input  wire logic [trss_pkg::DIST_IN_W-1:0] in_distance,
  input  wire trss_pkg::ctrl_cmd_t           cmd,
  output trss_pkg::ctrl_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_kind,
  output trss_pkg::node_t                    out_switch_node,
  output logic                               out_set_curved,
  output logic                               out_last
);
  import trss_pkg::*;

  node_rec_t node_mem [NODE_COUNT];
  dist_t     dist_mem [DIST_DEPTH];

  node_rec_t node_q_r;
  dist_t     dist_q_r;
  logic      dist_oor_r;
  dist_t     ds_r;
  logic      ds_oor_r;

  node_t     cur_r, cur_nxt;
  node_t     dst_r;
  hop_t      hop_r, hop_nxt;

  logic      out_valid_r;
  kind_t     out_kind_r;
  node_t     out_node_r;
  logic      out_curved_r;
  logic      out_last_r;

  node_t     rd_row;
  logic [2*NODE_IDX_W-1:0] rd_addr;
  logic [2*NODE_IDX_W-1:0] wr_addr;
  dist_t     ds_val;
  dist_t     dc_val;
  logic      go_straight;
  logic      out_free;

  // Node table: write on load, read one record per hop.
  always_ff @(posedge clk) begin
    if (cmd.load_node && node_in_range(in_node_id)) begin
      node_mem[in_node_id[NODE_IDX_W-1:0]] <= '{branch:   in_is_branch,
                                                 straight: in_next_straight,
                                                 curved:   in_next_curved};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_node) begin
      node_q_r <= node_mem[cur_r[NODE_IDX_W-1:0]];
    end
  end

  // Distance table: one write or one read per cycle.
  assign wr_addr = {in_node_id[NODE_IDX_W-1:0], in_target_id[NODE_IDX_W-1:0]};
  assign rd_row  = cmd.rd_dc ? node_q_r.curved : node_q_r.straight;
  assign rd_addr = {rd_row[NODE_IDX_W-1:0], dst_r[NODE_IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load_dist && node_in_range(in_node_id) && node_in_range(in_target_id)) begin
      dist_mem[wr_addr] <= DIST_BITS'(in_distance);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ds || cmd.rd_dc) begin
      dist_q_r   <= dist_mem[rd_addr];
      dist_oor_r <= !(node_in_range(rd_row) && node_in_range(dst_r));
    end
    // hold the straight distance while the curved one is fetched
    if (cmd.rd_dc) begin
      ds_r     <= dist_q_r;
      ds_oor_r <= dist_oor_r;
    end
  end

  assign ds_val      = ds_oor_r ? '1 : ds_r;
  assign dc_val      = dist_oor_r ? '1 : dist_q_r;
  assign go_straight = ds_val < dc_val;

  // Walk position and hop count.
  always_comb begin
    cur_nxt = cur_r;
    hop_nxt = hop_r;
    if (cmd.start) begin
      cur_nxt = in_node_id;
      hop_nxt = '0;
    end else if (cmd.adv_ahead) begin
      cur_nxt = node_q_r.straight;
      hop_nxt = hop_r + 1'b1;
    end else if (cmd.adv_branch) begin
      cur_nxt = go_straight ? node_q_r.straight : node_q_r.curved;
      hop_nxt = hop_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      hop_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      hop_r <= hop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dst_r <= in_target_id;
    end
  end

  // Output word register.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_node_r   <= cur_r;
      out_curved_r <= (cmd.kind == KIND_SWITCH) && !go_straight;
      out_last_r   <= (cmd.kind != KIND_SWITCH);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_switch_node = out_node_r;
  assign out_set_curved  = out_curved_r;
  assign out_last        = out_last_r;

  assign sts.at_dst    = (cur_r == dst_r);
  assign sts.stop      = !node_in_range(cur_r) || (hop_r >= HOP_W'(MAX_HOPS));
  assign sts.is_branch = node_q_r.branch;
  assign sts.out_free  = out_free;

endmodule

`default_nettype wire

/* rtl/trss_ctrl.sv */
`default_nettype none

`include "track_route_switch_setter_macros.svh"

module trss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_action,
  output logic                     in_ready,
  input  wire trss_pkg::ctrl_sts_t sts,
  output trss_pkg::ctrl_cmd_t      cmd
);
  import trss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_CHECK     = 5'b00010,
    ST_NODE_WAIT = 5'b00100,
    ST_DS_WAIT   = 5'b01000,
    ST_DC_WAIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_LOAD_NODE: cmd.load_node = 1'b1;
            ACT_LOAD_DIST: cmd.load_dist = 1'b1;
            ACT_ROUTE: begin
              cmd.start = 1'b1;
              state_nxt = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.at_dst) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_DONE;
            state_nxt = ST_IDLE;
          end
        end else if (sts.stop) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_ABORT;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.rd_node = 1'b1;
          state_nxt   = ST_NODE_WAIT;
        end
      end
      ST_NODE_WAIT: begin
        if (sts.is_branch) begin
          cmd.rd_ds = 1'b1;
          state_nxt = ST_DS_WAIT;
        end else begin
          cmd.adv_ahead = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_DS_WAIT: begin
        cmd.rd_dc = 1'b1;
        state_nxt = ST_DC_WAIT;
      end
      ST_DC_WAIT: begin
        // hold both distances until the output register frees up
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_SWITCH;
          cmd.adv_branch = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TRS_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "word emitted while output register full")
  `TRS_ASSERT_NXT(a_route_start, in_valid && in_ready && (in_action == ACT_ROUTE), state_r == ST_CHECK, "route request did not start walk")
  `TRS_ASSERT_NXT(a_final_idle, cmd.emit && (cmd.kind != KIND_SWITCH), state_r == ST_IDLE, "walk continued after final word")
  `TRS_ASSERT_IMP(a_read_walking, cmd.rd_node, !sts.at_dst && !sts.stop, "node read after walk ended")

endmodule

`default_nettype wire
